>>> rtl/assert_macros.svh
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

>>> rtl/hftm_pkg.sv
// ---------------------------------------------------------------------------
// hftm_pkg
// types and constants of the hashed flow table meter
// ---------------------------------------------------------------------------
`default_nettype none
package hftm_pkg;
  localparam int unsigned NumBuckets = 1021;
  localparam int unsigned Ways       = 4;
  localparam int unsigned BktW       = $clog2(NumBuckets);
  localparam int unsigned WayW       = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned Slots      = NumBuckets * Ways;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned QDepth     = 2;

  localparam logic [1:0] StUpdated = 2'd0;
  localparam logic [1:0] StCreated = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [47:0] time_us;
    logic [15:0] seg_len;
  } pkt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  bucket_index;
    logic [1:0]  way_index;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [47:0] first_seen_us;
    logic [47:0] last_seen_us;
  } res_out_t;

  // classified packet handed from front to back
  typedef struct packed {
    logic [95:0]     key;
    logic [47:0]     time_us;
    logic [15:0]     len;
    logic [BktW-1:0] bucket;
  } job_t;

  typedef struct packed {
    logic [95:0] key;
    logic [47:0] first_t;
    logic [47:0] last_t;
    logic [47:0] bytes;
    logic [31:0] pkts;
  } slot_t;
endpackage
`default_nettype wire

>>> rtl/hftm_front.sv
// ---------------------------------------------------------------------------
// hftm_front
// hashes the flow key and reduces it modulo NumBuckets to a bucket
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hftm_front import hftm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire pkt_in_t in_data_i,
  output logic         job_valid_o,
  input  wire logic    job_ready_i,
  output job_t         job_o
);
  // bucket = h mod NumBuckets by folding: 2^10 exceeds NumBuckets by FoldMul,
  // so the bits from bit 10 up fold back in times FoldMul
  localparam int unsigned ModSteps = 2;
  localparam int unsigned FoldMul  = 1024 - NumBuckets;

  typedef enum logic [1:0] {S_IDLE, S_MOD, S_OUT} state_e;

  state_e      state_q;
  logic [31:0] rem_q;
  logic [31:0] h_q;
  logic [1:0]  step_q;
  pkt_in_t     pkt_q;

  logic [31:0] h0, h1, h2, h3, h4;
  logic [31:0] rem_d;
  logic [23:0] f1;
  logic [15:0] f2;
  logic [10:0] f3;

  // xor-shift-add mix
  always_comb begin
    h0 = in_data_i.src_addr ^ in_data_i.dst_addr ^ {in_data_i.src_port, in_data_i.dst_port};
    h1 = h0 ^ (h0 >> 10);
    h2 = h1 + (h1 << 3);
    h3 = h2 ^ (h2 >> 6);
    h4 = h3 + (h3 << 14);
  end

  // two folds when step_q is 0, otherwise the last fold and one subtract
  always_comb begin
    f1 = 24'(h_q[31:10] * FoldMul) + 24'(h_q[9:0]);
    f2 = 16'(f1[23:10] * FoldMul) + 16'(f1[9:0]);
    f3 = 11'(rem_q[15:10] * FoldMul) + 11'(rem_q[9:0]);
    if (step_q == 2'd0) rem_d = 32'(f2);
    else if (f3 >= 11'(NumBuckets)) rem_d = 32'(f3 - 11'(NumBuckets));
    else rem_d = 32'(f3);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign job_valid_o = (state_q == S_OUT);
  assign job_o.key     = {pkt_q.src_addr, pkt_q.dst_addr, pkt_q.src_port, pkt_q.dst_port};
  assign job_o.time_us = pkt_q.time_us;
  assign job_o.len     = pkt_q.seg_len;
  assign job_o.bucket  = rem_q[BktW-1:0];

  // control and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      rem_q   <= '0;
      h_q     <= '0;
      pkt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            pkt_q   <= in_data_i;
            h_q     <= h4;
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q  <= rem_d;
          step_q <= step_q + 2'd1;
          if (step_q == 2'(ModSteps - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (job_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_bkt_range, clk_i, rst_ni, job_valid_o |-> (rem_q < 32'(NumBuckets)))
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (job_valid_o && !job_ready_i) |=> job_valid_o)
  `ASSERT_NEVER(a_no_take_busy, clk_i, rst_ni, in_ready_o && job_valid_o)
endmodule
`default_nettype wire

>>> rtl/hftm_queue.sv
// ---------------------------------------------------------------------------
// hftm_queue
// short job fifo between the hashing front and the table back
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hftm_queue import hftm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  wire job_t wr_data_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output job_t      rd_data_o
);
  localparam int unsigned PtrW = $clog2(QDepth);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, cnt_q <= (PtrW+1)'(QDepth))
  `ASSERT_IMPL(a_cnt_step, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
  `ASSERT_IMPL(a_ptr_gap, clk_i, rst_ni,
    ((cnt_q == '0) || (cnt_q == (PtrW+1)'(QDepth))) |-> (wp_q == rp_q))
endmodule
`default_nettype wire

>>> rtl/hftm_back.sv
// ---------------------------------------------------------------------------
// hftm_back
// reads the bucket ways one after another, matches, updates a hit or fills a free way, and emits the result
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module hftm_back import hftm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_out_t  out_data_o
);
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK, S_WRITE, S_OUT} state_e;

  // per-slot valid bits live in a memory of their own, cleared after reset
  slot_t           tbl_q [Slots];
  logic            vld_q [Slots];
  slot_t           rd_q;
  logic            rdv_q;

  state_e          state_q;
  job_t            job_q;
  logic [WayW:0]   way_q;
  logic            free_found_q;
  logic [WayW-1:0] free_way_q;
  logic [SlotW-1:0] clr_q;
  logic [SlotW-1:0] base_q;
  logic [SlotW-1:0] addr;
  logic            hit;
  slot_t           upd;
  logic [48:0]     bsum;
  res_out_t        res_q;
  logic            wr_en;
  logic [SlotW-1:0] wr_addr;
  slot_t           wr_data;
  logic            wv_en;
  logic [SlotW-1:0] wv_addr;
  logic            wv_data;

  assign addr = base_q + SlotW'(way_q);
  assign hit  = rdv_q && (rd_q.key == job_q.key);

  // hit update
  always_comb begin
    upd      = rd_q;
    bsum     = {1'b0, rd_q.bytes} + 49'(job_q.len);
    upd.bytes = bsum[48] ? '1 : bsum[47:0];
    if (job_q.time_us > rd_q.last_t) upd.last_t = job_q.time_us;
    if (rd_q.pkts != '1) upd.pkts = rd_q.pkts + 32'd1;
  end

  assign job_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  // table ports
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = upd;
    wv_en   = 1'b0;
    wv_addr = addr;
    wv_data = 1'b1;
    if (state_q == S_CLEAR) begin
      wv_en = 1'b1; wv_addr = clr_q; wv_data = 1'b0;
    end else if (state_q == S_CHECK && hit) begin
      wr_en = 1'b1;
    end else if (state_q == S_WRITE) begin
      wr_en   = 1'b1;
      wr_addr = base_q + SlotW'(free_way_q);
      wr_data = '{key: job_q.key, first_t: job_q.time_us, last_t: job_q.time_us,
                  bytes: 48'(job_q.len), pkts: 32'd1};
      wv_en   = 1'b1;
      wv_addr = wr_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) tbl_q[wr_addr] <= wr_data;
    if (wv_en) vld_q[wv_addr] <= wv_data;
    rd_q  <= tbl_q[addr];
    rdv_q <= vld_q[addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      way_q        <= '0;
      free_found_q <= 1'b0;
      free_way_q   <= '0;
      base_q       <= '0;
      job_q        <= '0;
      res_q        <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SlotW'(Slots - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid_i) begin
            job_q        <= job_i;
            base_q       <= SlotW'(job_i.bucket * Ways);
            way_q        <= '0;
            free_found_q <= 1'b0;
            state_q      <= S_READ;
          end
        end
        S_READ: state_q <= S_CHECK;
        S_CHECK: begin
          if (hit) begin
            res_q <= '{status: StUpdated, bucket_index: 10'(job_q.bucket),
                       way_index: 2'(way_q), flow_packets: upd.pkts, flow_bytes: upd.bytes,
                       first_seen_us: upd.first_t, last_seen_us: upd.last_t};
            state_q <= S_OUT;
          end else begin
            if (!rdv_q && !free_found_q) begin
              free_found_q <= 1'b1;
              free_way_q   <= way_q[WayW-1:0];
            end
            if (way_q == (WayW+1)'(Ways - 1)) begin
              if (free_found_q || !rdv_q) state_q <= S_WRITE;
              else begin
                res_q <= '{status: StFull, bucket_index: 10'(job_q.bucket),
                           default: '0};
                state_q <= S_OUT;
              end
            end else begin
              way_q   <= way_q + 1'b1;
              state_q <= S_READ;
            end
          end
        end
        S_WRITE: begin
          res_q <= '{status: StCreated, bucket_index: 10'(job_q.bucket),
                     way_index: 2'(free_way_q), flow_packets: 32'd1,
                     flow_bytes: 48'(job_q.len), first_seen_us: job_q.time_us,
                     last_seen_us: job_q.time_us};
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_way_range, clk_i, rst_ni, (state_q == S_CHECK) |-> (way_q < (WayW+1)'(Ways)))
  `ASSERT_IMPL(a_out_stat, clk_i, rst_ni, out_valid_o |-> (res_q.status != 2'd3))
  `ASSERT_NEVER(a_wr_clear, clk_i, rst_ni, wr_en && (state_q == S_CLEAR))
endmodule
`default_nettype wire

>>> rtl/hashed_flow_table_meter.sv
// ---------------------------------------------------------------------------
// hashed_flow_table_meter
// exact-match flow table that meters packets per four-tuple flow
// ---------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one packet item; out
//   channel (out_valid_o/out_ready_i/out_data_o) gives exactly one result
//   item per packet, in order.
//   the front hashes the key and folds it modulo the bucket count, and takes
//   no new item until its job is passed on; a 2-deep queue decouples it from
//   the back, which reads the ways of the bucket through the single table
//   read port (a read state and a check state per way) and writes back. the
//   back takes one job at a time and no new job until its result is taken.
//   after reset the back sweeps the valid bits, one slot a cycle, over all
//   4084 slots, during which items queue but no result comes out.
//   when the receiver stalls the result is held and the queue fills, then
//   in_ready_o drops.
// ---------------------------------------------------------------------------
`default_nettype none
module hashed_flow_table_meter import hftm_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire pkt_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output res_out_t     out_data_o
);
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  hftm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(fj_valid), .job_ready_i(fj_ready), .job_o(fj)
  );

  hftm_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fj_valid), .wr_ready_o(fj_ready), .wr_data_i(fj),
    .rd_valid_o(bj_valid), .rd_ready_i(bj_ready), .rd_data_o(bj)
  );

  hftm_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(bj_valid), .job_ready_o(bj_ready), .job_i(bj),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire
